>>> rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and codes for the sparse table builder.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_BADOP = 2'd2;

    localparam logic [1:0] MODE_MIN = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;
    localparam logic [1:0] MODE_OR  = 2'd2;
    localparam logic [1:0] MODE_AND = 2'd3;

    localparam logic [1:0] REG_COMBINE_MODE = 2'd0;
    localparam logic [1:0] REG_ZERO_AS_FULL = 2'd1;
    localparam logic [1:0] REG_USED_LENGTH  = 2'd2;
    localparam logic [1:0] REG_LEVEL_COUNT  = 2'd3;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] element_index;
        logic [3:0] level_select;
        logic [7:0] element_value;
    } req_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [1:0] status;
    } rsp_t;

endpackage

>>> rtl/stb_combine.sv
// ----------------------------------------------------------------------------
// stb_combine
// Combines two table entries by minimum, maximum, bitwise OR or bitwise AND.
// ----------------------------------------------------------------------------
module stb_combine
(
    input  logic [1:0] mode,
    input  logic [7:0] a,
    input  logic [7:0] b,
    output logic [7:0] y
);
    import stb_pkg::*;

    always_comb
    begin
        case (mode)
            MODE_MIN: y = (a < b) ? a : b;
            MODE_MAX: y = (a > b) ? a : b;
            MODE_OR:  y = a | b;
            MODE_AND: y = a & b;
            default:  y = a & b;
        endcase
    end

endmodule

>>> rtl/sparse_table_builder_core.sv
// ----------------------------------------------------------------------------
// sparse_table_builder_core
// Sparse table of bytes in one synchronous memory, built level by level.
// ----------------------------------------------------------------------------
// Loads and reads take one request per cycle while the result output is not
// stalled; a read result appears the cycle after acceptance, straight from the
// memory output register. A build walks the levels through the single write
// port, one entry per cycle: level k has a setup state, writes L - 2^k + 1
// entries (L is the used length clipped to the row size) and then drains the
// last write-back; a final level check ends it. No request is taken during a
// build. There is no clearing pass; unwritten entries read back arbitrary data.
module sparse_table_builder_core
#(
    parameter int INDEX_BITS = 8,
    parameter int MAX_LEVELS = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [8:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  stb_pkg::req_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output stb_pkg::rsp_t     out_data
);
    import stb_pkg::*;

    localparam int ROW_SIZE = 1 << INDEX_BITS;
    localparam int LVL_BITS = $clog2(MAX_LEVELS);
    localparam int ADDR_W   = LVL_BITS + INDEX_BITS;
    localparam int DEPTH    = MAX_LEVELS * ROW_SIZE;
    localparam int LEN_W    = INDEX_BITS + 1;
    localparam int KW       = LVL_BITS + 1;

    typedef enum logic [1:0] {S_IDLE, S_LEVEL, S_BUILD, S_DRAIN} state_t;

    logic [7:0]            store [DEPTH];
    logic [7:0]            rdata_a_reg;
    logic [7:0]            rdata_b_reg;

    state_t                state_reg, state_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [INDEX_BITS-1:0] j_reg, j_next;
    logic                  wb_valid_reg;
    logic [ADDR_W-1:0]     wb_addr_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic                  out_is_read_reg, out_is_read_next;

    logic [1:0]            combine_mode_reg;
    logic                  zero_as_full_reg;
    logic [8:0]            used_length_reg;
    logic [3:0]            level_count_reg;

    logic                  accept;
    logic                  idx_ok;
    logic                  lvl_ok;
    logic [INDEX_BITS-1:0] req_idx;
    logic [LVL_BITS-1:0]   req_lvl;
    logic [7:0]            load_value;
    logic [LEN_W-1:0]      len;
    logic [LEN_W-1:0]      window;
    logic [LEN_W-1:0]      half;
    logic [LEN_W-1:0]      last_j;
    logic                  level_go;
    logic [LVL_BITS-1:0]   row_lo;
    logic [INDEX_BITS-1:0] j_hi;
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_W-1:0]     waddr;
    logic [7:0]            wdata;
    logic [ADDR_W-1:0]     raddr_a;
    logic [ADDR_W-1:0]     raddr_b;
    logic [7:0]            comb_y;

    stb_combine u_combine
    (
        .mode (combine_mode_reg),
        .a    (rdata_a_reg),
        .b    (rdata_b_reg),
        .y    (comb_y)
    );

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign idx_ok  = 16'(in_data.element_index) < 16'(ROW_SIZE);
    assign lvl_ok  = 16'(in_data.level_select) < 16'(MAX_LEVELS);
    assign req_idx = INDEX_BITS'(in_data.element_index);
    assign req_lvl = LVL_BITS'(in_data.level_select);
    assign load_value = (zero_as_full_reg && in_data.element_value == 8'd0) ?
                        FULL_BYTE : in_data.element_value;

    assign len = (16'(used_length_reg) > 16'(ROW_SIZE)) ? LEN_W'(ROW_SIZE) :
                 LEN_W'(used_length_reg);
    assign window = LEN_W'(1) << k_reg;
    assign half   = window >> 1;
    assign last_j = len - window;
    assign level_go = (16'(k_reg) < 16'(level_count_reg)) &&
                      (16'(k_reg) < 16'(MAX_LEVELS)) &&
                      (16'(k_reg) <= 16'(INDEX_BITS)) &&
                      (window <= len);

    assign row_lo = LVL_BITS'(k_reg - KW'(1));
    assign j_hi   = INDEX_BITS'(LEN_W'(j_reg) + half);

    assign mem_re  = (accept && in_data.opcode == OP_READ && idx_ok && lvl_ok) ||
                     (state_reg == S_BUILD);
    assign raddr_a = (state_reg == S_BUILD) ? {row_lo, j_reg} : {req_lvl, req_idx};
    assign raddr_b = {row_lo, j_hi};

    assign mem_we = wb_valid_reg || (accept && in_data.opcode == OP_LOAD && idx_ok);
    assign waddr  = wb_valid_reg ? wb_addr_reg : {LVL_BITS'(0), req_idx};
    assign wdata  = wb_valid_reg ? comb_y : load_value;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_a_reg <= store[raddr_a];
            rdata_b_reg <= store[raddr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg <= {LVL_BITS'(k_reg), j_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            combine_mode_reg <= MODE_MIN;
            zero_as_full_reg <= 1'b0;
            used_length_reg  <= 9'd256;
            level_count_reg  <= 4'd9;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_COMBINE_MODE: combine_mode_reg <= cfg_wdata[1:0];
                REG_ZERO_AS_FULL: zero_as_full_reg <= cfg_wdata[0];
                REG_USED_LENGTH:  used_length_reg  <= cfg_wdata;
                REG_LEVEL_COUNT:  level_count_reg  <= cfg_wdata[3:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        j_next           = j_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_is_read_next = out_is_read_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.opcode)
                        OP_LOAD:
                        begin
                            out_valid_next   = 1'b1;
                            out_is_read_next = 1'b0;
                            out_status_next  = idx_ok ? ST_DONE : ST_RANGE;
                        end
                        OP_BUILD:
                        begin
                            k_next     = KW'(1);
                            state_next = S_LEVEL;
                        end
                        OP_READ:
                        begin
                            out_valid_next   = 1'b1;
                            out_is_read_next = idx_ok && lvl_ok;
                            out_status_next  = (idx_ok && lvl_ok) ? ST_DONE : ST_RANGE;
                        end
                        default:
                        begin
                            out_valid_next   = 1'b1;
                            out_is_read_next = 1'b0;
                            out_status_next  = ST_BADOP;
                        end
                    endcase
                end
            end
            S_LEVEL:
            begin
                if (level_go)
                begin
                    j_next     = '0;
                    state_next = S_BUILD;
                end
                else
                begin
                    out_valid_next   = 1'b1;
                    out_is_read_next = 1'b0;
                    out_status_next  = ST_DONE;
                    state_next       = S_IDLE;
                end
            end
            S_BUILD:
            begin
                if (LEN_W'(j_reg) == last_j)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + INDEX_BITS'(1);
                end
            end
            S_DRAIN:
            begin
                k_next     = k_reg + KW'(1);
                state_next = S_LEVEL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            k_reg           <= KW'(1);
            j_reg           <= '0;
            wb_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_DONE;
            out_is_read_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            k_reg           <= k_next;
            j_reg           <= j_next;
            wb_valid_reg    <= (state_reg == S_BUILD);
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_is_read_reg <= out_is_read_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_data.status     = out_status_reg;
    assign out_data.read_value = out_is_read_reg ? rdata_a_reg : 8'd0;

    // write-back never collides with a load
    a_wb_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> !accept)
        else $error("build write-back overlaps a request");

    // write-back follows a build issue cycle
    a_wb_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> $past(state_reg == S_BUILD))
        else $error("write-back without a build read");

    // no result is pending while a build runs
    a_build_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD || state_reg == S_DRAIN) |-> !out_valid_reg)
        else $error("result pending during build");

    // error results carry zero data
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_DONE) |-> out_data.read_value == 8'd0)
        else $error("error result carries data");

    // a level starts with the first entry
    a_level_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEVEL && level_go) |=> (state_reg == S_BUILD && j_reg == '0))
        else $error("level did not start at entry zero");

endmodule
